>>> rtl/frpg_pkg.sv
package frpg_pkg;

  // Sine table depth used unless the top level is given another
  localparam int SINE_DEPTH_DEFAULT = 1024;

  // Fixed-point constants for the quarter-wave table and the smooth ramp term
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] INV_PI_Q24  = 64'd5340354;

  // Register reset values
  localparam logic [15:0] RST_MAGNITUDE   = 16'hFFFF;
  localparam logic [31:0] RST_FREQ_START  = 32'd3276800;
  localparam logic [31:0] RST_RAMP_LENGTH = 32'd1048576;

  // Register indexes on the configuration channel
  localparam int          CFG_IDX_W         = 8;
  localparam logic [7:0]  REG_MAGNITUDE     = 8'd0;
  localparam logic [7:0]  REG_INITIAL_PHASE = 8'd1;
  localparam logic [7:0]  REG_FREQ_START    = 8'd2;
  localparam logic [7:0]  REG_RAMP_RATE     = 8'd3;
  localparam logic [7:0]  REG_RAMP_BEGIN    = 8'd4;
  localparam logic [7:0]  REG_RAMP_LENGTH   = 8'd5;
  localparam logic [7:0]  REG_SMOOTH_SHAPE  = 8'd6;
  localparam logic [7:0]  REG_ABSOLUTE_MODE = 8'd7;

  // Datapath operations, one per cycle
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_FREQ_FS,
    OP_FREQ_LIN,
    OP_PHASE_INC,
    OP_ACC_INIT,
    OP_ACC_ADD,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DFQ,
    OP_A,
    OP_R1,
    OP_V,
    OP_ACC_ADD4,
    OP_FREQ_SM,
    OP_PH_ABS,
    OP_OUT_RE,
    OP_OUT_IM,
    OP_EMIT
  } dp_op_t;

  // Operand pairs for the shared multiplier
  typedef enum logic [3:0] {
    M_RATE_X,
    M_FNOW_DT,
    M_FS_T,
    M_TMP_Y,
    M_RATE_L,
    M_L_ST,
    M_AH_INV,
    M_AL_INV,
    M_DFQ_V,
    M_DFQ_M,
    M_MAG_C,
    M_MAG_S
  } mul_sel_t;

  // Phase sources for a table lookup
  typedef enum logic [1:0] {
    L_TH,
    L_THC,
    L_PH,
    L_PHC
  } look_sel_t;

  // Destinations for a finished table lookup
  typedef enum logic [2:0] {
    TK_NONE,
    TK_ST,
    TK_CT,
    TK_C,
    TK_S
  } take_t;

  typedef struct packed {
    dp_op_t    op;
    logic      mul_go;
    mul_sel_t  msel;
    logic      look;
    look_sel_t lsel;
    take_t     take;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic pre_ramp;
    logic after;
    logic smooth;
    logic absolute;
  } dp_status_t;

endpackage

>>> rtl/frpg_if.sv
interface frpg_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface frpg_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_time;
  modport source (output valid, sample_time, input ready);
  modport sink (input valid, sample_time, output ready);
endinterface

interface frpg_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] out_real;
  logic signed [16:0] out_imag;
  logic signed [31:0] freq_now;
  modport source (output valid, out_real, out_imag, freq_now, input ready);
  modport sink (input valid, out_real, out_imag, freq_now, output ready);
endinterface

>>> rtl/frpg_dp.sv
module frpg_dp import frpg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic [31:0]          sample_time,
  input  dp_cmd_t              cmd,
  output dp_status_t           status,
  output logic signed [16:0]   out_real,
  output logic signed [16:0]   out_imag,
  output logic signed [31:0]   freq_now
);

  localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int SW = 30 + IW + 1;

  typedef logic [16:0] rom_t [SINE_TABLE_DEPTH+1];

  // Build the quarter-wave table from the odd power series
  function automatic rom_t build_rom();
    rom_t               tbl;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        e;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = signed'(x);
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / 64'((2 * n) * (2 * n + 1));
        if ((n & 1) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = '0;
      e = (64'(sum) + (64'd1 << 13)) >> 14;
      if (e > 64'd65536) e = 64'd65536;
      tbl[k] = e[16:0];
    end
    return tbl;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Configuration registers and phase state
  logic [15:0]        magnitude;
  logic [31:0]        initial_phase;
  logic signed [31:0] freq_start;
  logic signed [31:0] ramp_rate;
  logic [31:0]        ramp_begin;
  logic [31:0]        ramp_length;
  logic               smooth_shape;
  logic               absolute_mode;
  logic [31:0]        phase_accum;
  logic [31:0]        prev_time;

  // Working registers
  logic [31:0]        t_q;
  logic [31:0]        d;
  logic               pre_ramp;
  logic               after;
  logic signed [31:0] fnow;
  logic [63:0]        acc;
  logic [63:0]        tmp;
  logic signed [63:0] dfq;
  logic signed [63:0] a;
  logic signed [63:0] r;
  logic [31:0]        rem;
  logic [31:0]        quo;
  logic signed [17:0] st;
  logic signed [17:0] ct;
  logic signed [17:0] c;
  logic signed [17:0] s;
  logic signed [16:0] re_q;
  logic signed [16:0] im_q;

  // Multiplier
  logic [63:0] opa;
  logic [63:0] opb;
  logic [63:0] ma;
  logic [63:0] mb;
  logic [2:0]  mstep;
  logic [31:0] mx;
  logic [31:0] my;
  logic [63:0] pp;
  logic [63:0] prod;

  // Table lookup
  logic [31:0]        lp;
  logic [SW-1:0]      scaled;
  logic [IW-1:0]      idx_raw;
  logic [IW-1:0]      idx;
  logic [16:0]        rom_q;
  logic               rom_neg;
  logic signed [17:0] sval;

  logic [32:0]        dt33;
  logic [33:0]        span;
  logic [32:0]        div_sh;
  logic [63:0]        acc_rnd;
  logic signed [63:0] fs64;

  assign status.mul_done = (mstep == 3'd4);
  assign status.pre_ramp = pre_ramp;
  assign status.after    = after;
  assign status.smooth   = smooth_shape;
  assign status.absolute = absolute_mode;

  assign dt33    = {1'b0, t_q} - {1'b0, prev_time};
  assign span    = {1'b0, d, 1'b0} - {2'b00, ramp_length};
  assign div_sh  = {rem, 1'b0};
  assign acc_rnd = acc + (64'd1 << 24);
  assign fs64    = 64'(freq_start);

  // Pick multiplier operands, all taken modulo 2^64
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.msel)
      M_RATE_X: begin
        ma = 64'(ramp_rate);
        mb = after ? {32'd0, ramp_length} : {32'd0, d};
      end
      M_FNOW_DT: begin
        ma = 64'(fnow);
        mb = 64'($signed(dt33));
      end
      M_FS_T: begin
        ma = fs64;
        mb = {32'd0, t_q};
      end
      M_TMP_Y: begin
        ma = tmp;
        mb = after ? {30'd0, span} : {32'd0, d};
      end
      M_RATE_L: begin
        ma = 64'(ramp_rate);
        mb = {32'd0, ramp_length};
      end
      M_L_ST: begin
        ma = {32'd0, ramp_length};
        mb = 64'(st);
      end
      M_AH_INV: begin
        ma = a >>> 24;
        mb = INV_PI_Q24;
      end
      M_AL_INV: begin
        ma = {40'd0, a[23:0]};
        mb = INV_PI_Q24;
      end
      M_DFQ_V: begin
        ma = dfq;
        mb = tmp;
      end
      M_DFQ_M: begin
        ma = dfq;
        mb = 64'(19'sd65536 - 19'(ct));
      end
      M_MAG_C: begin
        ma = {48'd0, magnitude};
        mb = 64'(c);
      end
      M_MAG_S: begin
        ma = {48'd0, magnitude};
        mb = 64'(s);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // Select the 32x32 partial product for this step
  always_comb begin
    unique case (mstep)
      3'd2: begin
        mx = opa[31:0];
        my = opb[63:32];
      end
      3'd3: begin
        mx = opa[63:32];
        my = opb[31:0];
      end
      default: begin
        mx = opa[31:0];
        my = opb[31:0];
      end
    endcase
  end

  // Step the multiplier: low product, then the two cross terms
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= '0;
    end else if (cmd.mul_go) begin
      mstep <= 3'd1;
    end else if (mstep == 3'd4) begin
      mstep <= '0;
    end else if (mstep != 3'd0) begin
      mstep <= mstep + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      opa <= ma;
      opb <= mb;
    end
    pp <= mx * my;
    if (mstep == 3'd2) begin
      prod <= pp;
    end else if (mstep == 3'd3 || mstep == 3'd4) begin
      prod <= prod + {pp[31:0], 32'd0};
    end
  end

  // Map a phase to its quadrant and nearest table entry
  always_comb begin
    unique case (cmd.lsel)
      L_TH:    lp = quo;
      L_THC:   lp = quo + 32'h4000_0000;
      L_PH:    lp = phase_accum;
      L_PHC:   lp = phase_accum + 32'h4000_0000;
      default: lp = phase_accum;
    endcase
    scaled  = SW'(lp[29:0]) * SW'(SINE_TABLE_DEPTH) + (SW'(1) << 29);
    idx_raw = scaled[30+IW-1:30];
    idx     = lp[30] ? IW'(SINE_TABLE_DEPTH) - idx_raw : idx_raw;
  end

  always_ff @(posedge clk) begin
    if (cmd.look) begin
      rom_q   <= SINE_ROM[idx];
      rom_neg <= lp[31];
    end
  end

  assign sval = rom_neg ? -$signed({1'b0, rom_q}) : $signed({1'b0, rom_q});

  // Hold configuration and phase state
  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude     <= RST_MAGNITUDE;
      initial_phase <= '0;
      freq_start    <= RST_FREQ_START;
      ramp_rate     <= '0;
      ramp_begin    <= '0;
      ramp_length   <= RST_RAMP_LENGTH;
      smooth_shape  <= 1'b0;
      absolute_mode <= 1'b0;
      phase_accum   <= '0;
      prev_time     <= '0;
    end else if (cfg_we && cfg_index <= REG_ABSOLUTE_MODE) begin
      priority case (cfg_index)
        REG_MAGNITUDE:     magnitude     <= cfg_data[15:0];
        REG_INITIAL_PHASE: initial_phase <= cfg_data;
        REG_FREQ_START:    freq_start    <= cfg_data;
        REG_RAMP_RATE:     ramp_rate     <= cfg_data;
        REG_RAMP_BEGIN:    ramp_begin    <= cfg_data;
        REG_RAMP_LENGTH:   ramp_length   <= cfg_data;
        REG_SMOOTH_SHAPE:  smooth_shape  <= cfg_data[0];
        default:           absolute_mode <= cfg_data[0];
      endcase
      phase_accum <= (cfg_index == REG_INITIAL_PHASE) ? cfg_data : initial_phase;
      prev_time   <= '0;
    end else if (cmd.op == OP_PHASE_INC) begin
      phase_accum <= phase_accum + prod[35:4] + 32'(prod[3]);
      prev_time   <= t_q;
    end else if (cmd.op == OP_PH_ABS) begin
      phase_accum <= acc_rnd[56:25];
    end
  end

  // Apply datapath operations
  always_ff @(posedge clk) begin
    unique case (cmd.take)
      TK_ST:   st <= sval;
      TK_CT:   ct <= sval;
      TK_C:    c  <= sval;
      TK_S:    s  <= sval;
      default: ;
    endcase
    unique case (cmd.op)
      OP_LOAD: begin
        t_q      <= sample_time;
        d        <= sample_time - ramp_begin;
        pre_ramp <= (sample_time <= ramp_begin);
        after    <= ({1'b0, sample_time} > ({1'b0, ramp_begin} + {1'b0, ramp_length}));
      end
      OP_FREQ_FS: fnow <= freq_start;
      OP_FREQ_LIN: begin
        fnow <= sat32(fs64 + (($signed(prod) + 64'sd524288) >>> 20));
        tmp  <= prod;
      end
      OP_ACC_INIT: begin
        acc  <= {7'd0, initial_phase, 25'd0} + (prod << 21);
        fnow <= freq_start;
      end
      OP_ACC_ADD: acc <= acc + prod;
      OP_DIV_INIT: begin
        if (d >= ramp_length) begin
          quo <= 32'd1;
          rem <= d - ramp_length;
        end else begin
          quo <= 32'd0;
          rem <= d;
        end
      end
      OP_DIV_STEP: begin
        if (div_sh >= {1'b0, ramp_length}) begin
          rem <= 32'(div_sh - {1'b0, ramp_length});
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= div_sh[31:0];
          quo <= {quo[30:0], 1'b0};
        end
      end
      OP_DFQ: dfq <= ($signed(prod) + 64'sd524288) >>> 20;
      OP_A:   a   <= prod;
      OP_R1:  r   <= prod;
      OP_V:   tmp <= ({32'd0, d} << 16) - (r + ((prod + (64'd1 << 23)) >> 24));
      OP_ACC_ADD4: acc <= acc + (prod << 4);
      OP_FREQ_SM: fnow <= sat32(fs64 + (($signed(prod) + 64'sd65536) >>> 17));
      OP_OUT_RE: re_q <= 17'(($signed(prod) + 64'sd32768) >>> 16);
      OP_OUT_IM: im_q <= 17'(($signed(prod) + 64'sd32768) >>> 16);
      OP_EMIT: begin
        out_real <= re_q;
        out_imag <= im_q;
        freq_now <= fnow;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/frpg_ctrl.sv
module frpg_ctrl import frpg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  localparam logic [4:0] DIV_LAST = 5'd30;

  typedef enum logic [5:0] {
    S_IDLE, S_MW,
    S_I0, S_I1, S_I2, S_I3,
    S_A0, S_A1, S_A2, S_A3, S_A4, S_A5,
    S_D0, S_D1, S_D2, S_D3, S_D4, S_D5, S_D6, S_D7, S_D8, S_D9,
    S_D10, S_D11, S_D12, S_D13, S_D14, S_D15,
    S_PH, S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_DONE
  } state_t;

  state_t     state;
  state_t     ret;
  logic [4:0] cnt;
  logic       emit_ok;

  assign in_ready = (state == S_IDLE);
  assign emit_ok  = !out_valid || out_ready;

  // Decode the command for the current step
  always_comb begin
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.msel   = M_RATE_X;
    cmd.lsel   = L_PH;
    cmd.take   = TK_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_I0: begin
        if (status.pre_ramp) cmd.op = OP_FREQ_FS;
        else cmd.mul_go = 1'b1;
      end
      S_I1: cmd.op = OP_FREQ_LIN;
      S_I2: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_FNOW_DT;
      end
      S_I3: cmd.op = OP_PHASE_INC;
      S_A0: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_FS_T;
      end
      S_A1: cmd.op = OP_ACC_INIT;
      S_A2: cmd.mul_go = 1'b1;
      S_A3: cmd.op = OP_FREQ_LIN;
      S_A4: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_TMP_Y;
      end
      S_A5: cmd.op = OP_ACC_ADD;
      S_D0: cmd.op = OP_DIV_INIT;
      S_D1: cmd.op = OP_DIV_STEP;
      S_D2: begin
        cmd.look = 1'b1;
        cmd.lsel = L_TH;
      end
      S_D3: begin
        cmd.look = 1'b1;
        cmd.lsel = L_THC;
        cmd.take = TK_ST;
      end
      S_D4: begin
        cmd.take   = TK_CT;
        cmd.mul_go = 1'b1;
        cmd.msel   = M_RATE_L;
      end
      S_D5: cmd.op = OP_DFQ;
      S_D6: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_L_ST;
      end
      S_D7: cmd.op = OP_A;
      S_D8: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_AH_INV;
      end
      S_D9: cmd.op = OP_R1;
      S_D10: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_AL_INV;
      end
      S_D11: cmd.op = OP_V;
      S_D12: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_DFQ_V;
      end
      S_D13: cmd.op = OP_ACC_ADD4;
      S_D14: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_DFQ_M;
      end
      S_D15: cmd.op = OP_FREQ_SM;
      S_PH:  cmd.op = OP_PH_ABS;
      S_T0: begin
        cmd.look = 1'b1;
        cmd.lsel = L_PHC;
      end
      S_T1: begin
        cmd.look = 1'b1;
        cmd.lsel = L_PH;
        cmd.take = TK_C;
      end
      S_T2: begin
        cmd.take   = TK_S;
        cmd.mul_go = 1'b1;
        cmd.msel   = M_MAG_C;
      end
      S_T3: cmd.op = OP_OUT_RE;
      S_T4: begin
        cmd.mul_go = 1'b1;
        cmd.msel   = M_MAG_S;
      end
      S_T5: cmd.op = OP_OUT_IM;
      S_DONE: if (emit_ok) cmd.op = OP_EMIT;
      default: ;
    endcase
  end

  // Advance the sequence and hold the result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      ret       <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && emit_ok) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= status.absolute ? S_A0 : S_I0;
        S_MW:   if (status.mul_done) state <= ret;
        S_I0: begin
          if (status.pre_ramp) begin
            state <= S_I2;
          end else begin
            state <= S_MW;
            ret   <= S_I1;
          end
        end
        S_I1: state <= S_I2;
        S_I2: begin
          state <= S_MW;
          ret   <= S_I3;
        end
        S_I3: state <= S_T0;
        S_A0: begin
          state <= S_MW;
          ret   <= S_A1;
        end
        S_A1: begin
          priority if (status.pre_ramp) state <= S_PH;
          else if (status.after || !status.smooth) state <= S_A2;
          else state <= S_D0;
        end
        S_A2: begin
          state <= S_MW;
          ret   <= S_A3;
        end
        S_A3: state <= S_A4;
        S_A4: begin
          state <= S_MW;
          ret   <= S_A5;
        end
        S_A5: state <= S_PH;
        S_D0: begin
          state <= S_D1;
          cnt   <= '0;
        end
        S_D1: begin
          cnt <= cnt + 5'd1;
          if (cnt == DIV_LAST) state <= S_D2;
        end
        S_D2: state <= S_D3;
        S_D3: state <= S_D4;
        S_D4: begin
          state <= S_MW;
          ret   <= S_D5;
        end
        S_D5: state <= S_D6;
        S_D6: begin
          state <= S_MW;
          ret   <= S_D7;
        end
        S_D7: state <= S_D8;
        S_D8: begin
          state <= S_MW;
          ret   <= S_D9;
        end
        S_D9: state <= S_D10;
        S_D10: begin
          state <= S_MW;
          ret   <= S_D11;
        end
        S_D11: state <= S_D12;
        S_D12: begin
          state <= S_MW;
          ret   <= S_D13;
        end
        S_D13: state <= S_D14;
        S_D14: begin
          state <= S_MW;
          ret   <= S_D15;
        end
        S_D15: state <= S_PH;
        S_PH:  state <= S_T0;
        S_T0:  state <= S_T1;
        S_T1:  state <= S_T2;
        S_T2: begin
          state <= S_MW;
          ret   <= S_T3;
        end
        S_T3: state <= S_T4;
        S_T4: begin
          state <= S_MW;
          ret   <= S_T5;
        end
        S_T5: state <= S_DONE;
        S_DONE: if (emit_ok) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/frequency_ramp_phasor_generator_unit.sv
// Chirp phasor generator: turns each time stamp into a phasor and a frequency.
//
// Channels: regs writes one configuration register per item (index, data);
// it is always ready; writes to 0-7 reload the phase from initial_phase and
// clear the last time stamp. samples carries one time stamp per item,
// results one phasor (out_real, out_imag) and the current frequency.
//
// One item is worked at a time by a sequencer over one shared 32x32
// multiplier, which forms each 64-bit product, and a quarter-wave sine
// table with a registered read. The steps taken depend on the mode:
// incremental, absolute with a linear ramp (fewer steps before the ramp
// starts), or absolute with the raised-cosine ramp, whose 32-step
// divider and extra products make it the longest. The next time stamp
// is taken the cycle after the result enters the output register.
//
// Reset restores the configuration defaults and clears the phase.
// A stalled receiver holds the result; the block then finishes the item
// in hand and waits with its ready low until the output register frees.
module frequency_ramp_phasor_generator_unit import frpg_pkg::*; #(
  parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
  input logic clk,
  input logic rst,
  frpg_cfg_if.sink    regs,
  frpg_in_if.sink     samples,
  frpg_out_if.source  results
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // Registers take every write
  assign regs.ready = 1'b1;

  frpg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  frpg_dp #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (regs.valid),
    .cfg_index   (regs.index),
    .cfg_data    (regs.data),
    .sample_time (samples.sample_time),
    .cmd         (cmd),
    .status      (status),
    .out_real    (results.out_real),
    .out_imag    (results.out_imag),
    .freq_now    (results.freq_now)
  );

endmodule

>>> dv/tb_frequency_ramp_phasor_generator_unit.sv
`timescale 1ns / 100ps

module tb_frequency_ramp_phasor_generator_unit;
  import frpg_pkg::*;

  localparam int  DEPTH       = SINE_DEPTH_DEFAULT;
  localparam int  IDLE_CYCLES = 160;
  localparam int  STALL_LIMIT = 6000;

  typedef struct packed {
    logic signed [16:0] re;
    logic signed [16:0] im;
    logic signed [31:0] freq;
  } phasor_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  frpg_cfg_if regs ();
  frpg_in_if  samples ();
  frpg_out_if results ();

  frequency_ramp_phasor_generator_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .regs    (regs.sink),
    .samples (samples.sink),
    .results (results.source)
  );

  always #6 clk = ~clk;

  // Chirp state mirrored from the register file
  logic [15:0]        cfg_magnitude;
  logic [31:0]        cfg_init_phase;
  logic signed [31:0] cfg_freq_start;
  logic signed [31:0] cfg_ramp_rate;
  logic [31:0]        cfg_ramp_begin;
  logic [31:0]        cfg_ramp_length;
  logic               cfg_smooth;
  logic               cfg_absolute;
  logic [31:0]        phase_now;
  logic [31:0]        last_time;
  logic [16:0]        quarter_sine [0:DEPTH];

  phasor_t expected_phasors [$];
  int      error_count;
  int      samples_sent;
  int      phasors_seen;
  int      reg_writes;
  int      stall_cycles;
  int      burst_left;

  // Build the quarter-wave table by the integer Taylor series
  task automatic build_quarter_sine();
    longint unsigned x, x2, term, e;
    longint sum;
    for (int k = 0; k <= DEPTH; k++) begin
      x = (HALF_PI_Q30 * k + DEPTH / 2) / DEPTH;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = x;
      sum = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((term * x2 + (64'd1 << 29)) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2 == 1) sum -= term;
        else sum += term;
      end
      if (sum < 0) sum = 0;
      e = ($unsigned(sum) + (64'd1 << 13)) >> 14;
      if (e > 65536) e = 65536;
      quarter_sine[k] = e[16:0];
    end
  endtask

  function automatic longint round_shift(longint x, int n);
    longint y;
    y = x + (64'sd1 << (n - 1));
    return y >>> n;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint table_sine(logic [31:0] p);
    longint unsigned idx;
    longint v;
    idx = ({34'd0, p[29:0]} * DEPTH + (64'd1 << 29)) >> 30;
    if (idx > DEPTH) idx = DEPTH;
    if (p[30]) idx = DEPTH - idx;
    v = {47'd0, quarter_sine[idx]};
    return p[31] ? -v : v;
  endfunction

  task automatic chirp_defaults();
    cfg_magnitude   = RST_MAGNITUDE;
    cfg_init_phase  = '0;
    cfg_freq_start  = RST_FREQ_START;
    cfg_ramp_rate   = '0;
    cfg_ramp_begin  = '0;
    cfg_ramp_length = RST_RAMP_LENGTH;
    cfg_smooth      = 1'b0;
    cfg_absolute    = 1'b0;
    phase_now       = '0;
    last_time       = '0;
  endtask

  task automatic chirp_write(logic [7:0] idx, logic [31:0] data);
    case (idx)
      REG_MAGNITUDE:     cfg_magnitude = data[15:0];
      REG_INITIAL_PHASE: cfg_init_phase = data;
      REG_FREQ_START:    cfg_freq_start = data;
      REG_RAMP_RATE:     cfg_ramp_rate = data;
      REG_RAMP_BEGIN:    cfg_ramp_begin = data;
      REG_RAMP_LENGTH:   cfg_ramp_length = data;
      REG_SMOOTH_SHAPE:  cfg_smooth = data[0];
      REG_ABSOLUTE_MODE: cfg_absolute = data[0];
      default:           return;
    endcase
    phase_now = cfg_init_phase;
    last_time = '0;
  endtask

  // Advance the chirp by one time stamp and return its phasor
  function automatic phasor_t chirp_step(logic [31:0] t);
    longint fs, rate, len, end_t, tl, fnow, dt, prod, d, dfq, a, ah, al, r, v, st, ct;
    logic [63:0] acc, tmp, th64;
    logic [31:0] ph;
    phasor_t res;
    fs = cfg_freq_start;
    rate = cfg_ramp_rate;
    len = {32'd0, cfg_ramp_length};
    end_t = {32'd0, cfg_ramp_begin} + len;
    tl = {32'd0, t};
    if (!cfg_absolute) begin
      if (t <= cfg_ramp_begin) fnow = fs;
      else if (tl <= end_t) fnow = fs + round_shift(rate * (tl - cfg_ramp_begin), 20);
      else fnow = fs + round_shift(rate * len, 20);
      fnow = clamp32(fnow);
      dt = tl - {32'd0, last_time};
      prod = fnow * dt;
      tmp = prod + 64'd8;
      phase_now = phase_now + tmp[35:4];
      last_time = t;
      ph = phase_now;
    end else begin
      acc = {32'd0, cfg_init_phase} << 25;
      prod = fs * tl;
      acc = acc + (prod << 21);
      fnow = fs;
      if (tl > end_t) begin
        acc = acc + rate * len * (len + 2 * (tl - end_t));
        fnow = fs + round_shift(rate * len, 20);
      end else if (t > cfg_ramp_begin) begin
        d = tl - {32'd0, cfg_ramp_begin};
        if (cfg_smooth && len != 0) begin
          th64 = (64'(d) << 31) / 64'(len);
          st = table_sine(th64[31:0]);
          ct = table_sine(th64[31:0] + 32'h4000_0000);
          dfq = round_shift(rate * len, 20);
          a = len * st;
          ah = a >>> 24;
          al = a & 64'hFF_FFFF;
          r = ah * longint'(INV_PI_Q24) +
              ((al * longint'(INV_PI_Q24) + (64'sd1 << 23)) >>> 24);
          v = d * 65536 - r;
          acc = acc + ((dfq * v) << 4);
          fnow = fs + round_shift(dfq * (65536 - ct), 17);
        end else begin
          acc = acc + rate * d * d;
          fnow = fs + round_shift(rate * d, 20);
        end
      end
      fnow = clamp32(fnow);
      tmp = acc + (64'd1 << 24);
      ph = tmp[56:25];
      phase_now = ph;
    end
    res.re = 17'(round_shift(longint'(cfg_magnitude) * table_sine(ph + 32'h4000_0000), 16));
    res.im = 17'(round_shift(longint'(cfg_magnitude) * table_sine(ph), 16));
    res.freq = fnow[31:0];
    return res;
  endfunction

  // Receiver: stall pattern switches between always-ready and random stalls
  int rx_mode_left = 0;
  int rx_mode = 0;
  always @(negedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(20, 200);
    end
    rx_mode_left--;
    case (rx_mode)
      0: results.ready <= 1'b1;
      1: results.ready <= ($urandom_range(0, 3) != 0);
      2: results.ready <= ($urandom_range(0, 3) == 0);
      default: results.ready <= ($urandom_range(0, 40) != 0) ? results.ready : ~results.ready;
    endcase
  end

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    phasor_t exp_p;
    if (!rst && results.valid && results.ready) begin
      phasors_seen++;
      if (expected_phasors.size() == 0) begin
        $error("unexpected result re=%0d im=%0d freq=%0d",
               results.out_real, results.out_imag, results.freq_now);
        error_count++;
      end else begin
        exp_p = expected_phasors.pop_front();
        if (results.out_real !== exp_p.re) begin
          $error("out_real expected %0d actual %0d", exp_p.re, results.out_real);
          error_count++;
        end
        if (results.out_imag !== exp_p.im) begin
          $error("out_imag expected %0d actual %0d", exp_p.im, results.out_imag);
          error_count++;
        end
        if (results.freq_now !== exp_p.freq) begin
          $error("freq_now expected %0d actual %0d", exp_p.freq, results.freq_now);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready) ||
        (regs.valid && regs.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("frequency_ramp_phasor_generator_unit test failed");
      $finish;
    end
  end

  // Send one time stamp, at times idling between bursts
  task automatic send_sample(logic [31:0] t);
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) begin
        samples.valid <= 1'b0;
        repeat ($urandom_range(1, 60)) @(negedge clk);
      end
    end
    burst_left--;
    samples.valid <= 1'b1;
    samples.sample_time <= t;
    do @(posedge clk); while (!samples.ready);
    expected_phasors.push_back(chirp_step(t));
    samples_sent++;
  endtask

  // Hold the input off until every result is back and the block is idle
  task automatic drain();
    @(negedge clk);
    samples.valid <= 1'b0;
    while (expected_phasors.size() != 0) @(negedge clk);
    repeat (IDLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [31:0] data);
    @(negedge clk);
    regs.valid <= 1'b1;
    regs.index <= idx;
    regs.data <= data;
    do @(posedge clk); while (!regs.ready);
    chirp_write(idx, data);
    reg_writes++;
    @(negedge clk);
    regs.valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_sample(32'd0);
    send_sample(32'd1);
    send_sample(32'd1048576);
    send_sample(32'd3000000);
    send_sample(32'd2999000);
    drain();
  endtask

  task automatic test_incremental_extremes();
    write_reg(REG_MAGNITUDE, 32'hFFFF_0000);
    write_reg(REG_INITIAL_PHASE, 32'hFFFF_FFFF);
    write_reg(REG_FREQ_START, 32'h7FFF_FFFF);
    write_reg(REG_RAMP_RATE, 32'h7FFF_FFFF);
    write_reg(REG_RAMP_BEGIN, 32'd100);
    write_reg(REG_RAMP_LENGTH, 32'hFFFF_FFFF);
    write_reg(REG_SMOOTH_SHAPE, 32'd1);
    send_sample(32'd50);
    send_sample(32'd5000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'd0);
    drain();
    write_reg(REG_FREQ_START, 32'h8000_0000);
    write_reg(REG_RAMP_RATE, 32'h8000_0000);
    write_reg(REG_RAMP_LENGTH, 32'd0);
    write_reg(REG_MAGNITUDE, 32'd65535);
    send_sample(32'd100);
    send_sample(32'd101);
    send_sample(32'hFFFF_FFFF);
    drain();
    write_reg(8'd200, 32'hDEAD_BEEF);
    send_sample(32'd7);
    drain();
  endtask

  task automatic test_absolute_ramps();
    write_reg(REG_ABSOLUTE_MODE, 32'hFFFF_FFFE);
    write_reg(REG_ABSOLUTE_MODE, 32'd1);
    write_reg(REG_FREQ_START, 32'd3276800);
    write_reg(REG_RAMP_RATE, 32'd655360);
    write_reg(REG_RAMP_BEGIN, 32'd1048576);
    write_reg(REG_RAMP_LENGTH, 32'd2097152);
    write_reg(REG_SMOOTH_SHAPE, 32'd0);
    send_sample(32'd1000);
    send_sample(32'd2000000);
    send_sample(32'd4000000);
    drain();
    write_reg(REG_SMOOTH_SHAPE, 32'd1);
    send_sample(32'd1048577);
    send_sample(32'd2097152);
    send_sample(32'd3145727);
    send_sample(32'hFFFF_FFFF);
    drain();
    write_reg(REG_RAMP_LENGTH, 32'd0);
    send_sample(32'd1048577);
    drain();
  endtask

  function automatic logic [31:0] pick_word(logic [31:0] typical);
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 32'd0;
      4: return $urandom();
      default: return typical;
    endcase
  endfunction

  task automatic test_random_chirps();
    logic [31:0] t, len, step;
    for (int phase = 0; phase < 26; phase++) begin
      drain();
      write_reg(REG_MAGNITUDE, pick_word($urandom()));
      write_reg(REG_INITIAL_PHASE, $urandom());
      write_reg(REG_FREQ_START, pick_word($urandom_range(0, 32'h0400_0000) - 32'h0200_0000));
      write_reg(REG_RAMP_RATE, pick_word($urandom_range(0, 32'h0400_0000) - 32'h0200_0000));
      write_reg(REG_RAMP_BEGIN, pick_word($urandom_range(0, 32'h0080_0000)));
      len = ($urandom_range(0, 12) == 0) ? pick_word(32'd0) : $urandom_range(1, 32'h0040_0000);
      write_reg(REG_RAMP_LENGTH, len);
      write_reg(REG_SMOOTH_SHAPE, $urandom());
      write_reg(REG_ABSOLUTE_MODE, (phase % 2 == 0) ? 32'd0 : $urandom());
      if ($urandom_range(0, 3) == 0) write_reg(8'($urandom_range(8, 255)), $urandom());
      // Sweep time across the ramp with occasional noise and backward steps
      t = cfg_ramp_begin - $urandom_range(0, 32'h0010_0000);
      step = (len == 0 || len > 32'h0100_0000) ? 32'h0004_0000 : len / 24 + 1;
      for (int i = 0; i < 50; i++) begin
        case ($urandom_range(0, 11))
          0:       t = $urandom();
          1:       t = t - $urandom_range(0, step);
          default: t = t + $urandom_range(0, step);
        endcase
        send_sample(t);
      end
    end
    drain();
  endtask

  initial begin
    error_count = 0;
    samples_sent = 0;
    phasors_seen = 0;
    reg_writes = 0;
    stall_cycles = 0;
    burst_left = 0;
    regs.valid = 1'b0;
    regs.index = '0;
    regs.data = '0;
    samples.valid = 1'b0;
    samples.sample_time = '0;
    results.ready = 1'b0;
    build_quarter_sine();
    chirp_defaults();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_incremental_extremes();
    test_absolute_ramps();
    test_random_chirps();
    $display("covered %0d time stamps, %0d results, %0d register writes", samples_sent,
             phasors_seen, reg_writes);
    $display("incremental and absolute phase, linear and smooth ramps, saturation");
    if (error_count == 0 && expected_phasors.size() == 0)
      $display("frequency_ramp_phasor_generator_unit test passed");
    else
      $display("frequency_ramp_phasor_generator_unit test failed");
    $finish;
  end

endmodule
